// ===== rtl/assert_macros.svh =====
// assertion macros shared by the record stack modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds on every clock edge outside reset
`define VLRS_ASSERT_ALWAYS(lbl, clk_s, rstn_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (prop)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define VLRS_ASSERT_IMPLY(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error(msg);

// consequent holds in the cycle after the antecedent
`define VLRS_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/vlrs_pkg.sv =====
// shared constants, codes and controller/datapath interface types
// for the variable-length record stack; no dependencies
package vlrs_pkg;

	localparam int STORE_BYTES  = 1024;
	localparam int LENGTH_BYTES = 2;
	localparam int MAX_RECORD   = 64;

	localparam int ADDR_W = $clog2(STORE_BYTES);
	localparam int PTR_W  = $clog2(STORE_BYTES + 1);
	localparam int FIT_W  = PTR_W + 1;
	localparam int LEN_W  = 7;
	localparam int CNT_W  = $clog2(LENGTH_BYTES + 1);

	typedef enum logic [2:0] {
		OP_PUSH  = 3'd0,
		OP_POP   = 3'd1,
		OP_PEEK  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_PROBE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_TRAIL,
		S_TRD,
		S_TCAP,
		S_CALC,
		S_START,
		S_BRD,
		S_BOUT,
		S_RES
	} state_t;

	typedef struct packed {
		logic latch_in;
		logic exec;
		logic trail_wr;
		logic trd_rd;
		logic trd_cap;
		logic calc_stored;
		logic calc_start;
		logic byte_rd;
		logic load_res;
		logic load_byte;
	} cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       last;
		logic       rec_accept;
		logic       top_short;
		logic       cnt_zero;
		logic       cnt_top;
		logic       n_zero;
		logic       idx_last;
		logic       out_free;
	} sts_t;

endpackage

// ===== rtl/vlrs_dp.sv =====
// datapath of the record stack: byte store, pointers, trailer decode, output register
// depends on vlrs_pkg and assert_macros.svh
`include "assert_macros.svh"

module vlrs_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [2:0]                 operation,
	input  logic [7:0]                 data_byte,
	input  logic [vlrs_pkg::LEN_W-1:0] record_length,
	input  logic                       last_byte,
	input  vlrs_pkg::cmd_t             cmd,
	output vlrs_pkg::sts_t             sts,
	input  logic                       out_stall,
	output logic                       out_valid,
	output logic [1:0]                 status,
	output logic [7:0]                 out_byte,
	output logic                       has_byte,
	output logic                       final_res,
	output logic                       is_empty,
	output logic [vlrs_pkg::PTR_W-1:0] used_bytes
);

	logic [7:0] mem [vlrs_pkg::STORE_BYTES];

	logic [2:0]                 op_q;
	logic [7:0]                 data_q;
	logic [vlrs_pkg::LEN_W-1:0] len_q;
	logic                       last_q;

	logic [vlrs_pkg::PTR_W-1:0] top_q, base_q, t_q, start_q;
	logic [vlrs_pkg::LEN_W-1:0] bw_q, lim_q, tlen_q, stored_q, n_q, idx_q;
	logic                       open_q, acc_ok_q, big_q;
	logic [vlrs_pkg::CNT_W-1:0] cnt_q;
	vlrs_pkg::status_t          status_q;
	logic [7:0]                 rd_q;

	logic                       out_valid_q, has_q, final_q, empty_q;
	logic [1:0]                 out_status_q;
	logic [7:0]                 out_byte_q;
	logic [vlrs_pkg::PTR_W-1:0] used_q;

	logic                       opening, fits, eff_acc, do_wr, wr_en, rd_en, out_free;
	logic [vlrs_pkg::PTR_W-1:0] eff_base, push_addr, trail_addr, trail_end, wr_addr, rd_addr;
	logic [vlrs_pkg::PTR_W-1:0] start_c;
	logic [vlrs_pkg::LEN_W-1:0] eff_bw, eff_lim, stored_c, stored_cl, n_c;
	logic [7:0]                 trail_byte, wr_data;

	// push with record open logic
	assign opening  = !open_q;
	assign eff_base = opening ? top_q : base_q;
	assign eff_bw   = opening ? '0 : bw_q;
	assign eff_lim  = opening ? len_q : lim_q;
	assign fits     = (len_q <= vlrs_pkg::LEN_W'(vlrs_pkg::MAX_RECORD)) &&
		((vlrs_pkg::FIT_W'(len_q) + vlrs_pkg::FIT_W'(vlrs_pkg::LENGTH_BYTES)) <=
		(vlrs_pkg::FIT_W'(vlrs_pkg::STORE_BYTES) - vlrs_pkg::FIT_W'(top_q)));
	assign eff_acc  = opening ? fits : acc_ok_q;
	assign do_wr    = eff_acc && (eff_bw < eff_lim);

	assign push_addr  = eff_base + vlrs_pkg::PTR_W'(eff_bw);
	assign trail_addr = base_q + vlrs_pkg::PTR_W'(bw_q) + vlrs_pkg::PTR_W'(cnt_q);
	assign trail_end  = base_q + vlrs_pkg::PTR_W'(bw_q) +
		vlrs_pkg::PTR_W'(vlrs_pkg::LENGTH_BYTES);
	assign trail_byte = (cnt_q == '0) ? 8'(bw_q) : 8'h00;

	assign wr_en   = (cmd.exec && op_q == vlrs_pkg::OP_PUSH && do_wr) || cmd.trail_wr;
	assign wr_addr = cmd.trail_wr ? trail_addr : push_addr;
	assign wr_data = cmd.trail_wr ? trail_byte : data_q;
	assign rd_en   = cmd.trd_rd || cmd.byte_rd;
	assign rd_addr = cmd.trd_rd ? (t_q + vlrs_pkg::PTR_W'(cnt_q)) :
		(start_q + vlrs_pkg::PTR_W'(idx_q));

	// stored length clamp and byte count
	assign stored_c  = big_q ? vlrs_pkg::LEN_W'(vlrs_pkg::MAX_RECORD) : tlen_q;
	assign stored_cl = (vlrs_pkg::PTR_W'(stored_c) > t_q) ? vlrs_pkg::LEN_W'(t_q) : stored_c;
	assign start_c   = t_q - vlrs_pkg::PTR_W'(stored_q);
	assign n_c       = (len_q < stored_q) ? len_q : stored_q;

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		sts            = '0;
		sts.op         = op_q;
		sts.last       = last_q;
		sts.rec_accept = eff_acc;
		sts.top_short  = top_q < vlrs_pkg::PTR_W'(vlrs_pkg::LENGTH_BYTES);
		sts.cnt_zero   = cnt_q == '0;
		sts.cnt_top    = cnt_q == vlrs_pkg::CNT_W'(vlrs_pkg::LENGTH_BYTES - 1);
		sts.n_zero     = n_q == '0;
		sts.idx_last   = (idx_q + vlrs_pkg::LEN_W'(1)) == n_q;
		sts.out_free   = out_free;
	end

	// byte store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr[vlrs_pkg::ADDR_W-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr[vlrs_pkg::ADDR_W-1:0]];
		end
	end

	// item registers and stack state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q     <= '0;
			data_q   <= '0;
			len_q    <= '0;
			last_q   <= 1'b0;
			top_q    <= '0;
			base_q   <= '0;
			t_q      <= '0;
			start_q  <= '0;
			bw_q     <= '0;
			lim_q    <= '0;
			tlen_q   <= '0;
			stored_q <= '0;
			n_q      <= '0;
			idx_q    <= '0;
			open_q   <= 1'b0;
			acc_ok_q <= 1'b0;
			big_q    <= 1'b0;
			cnt_q    <= '0;
			status_q <= vlrs_pkg::ST_OK;
		end else begin
			if (cmd.latch_in) begin
				op_q   <= operation;
				data_q <= data_byte;
				len_q  <= record_length;
				last_q <= last_byte;
			end
			if (cmd.exec) begin
				if (op_q == vlrs_pkg::OP_PUSH) begin
					open_q   <= !last_q;
					acc_ok_q <= eff_acc;
					base_q   <= eff_base;
					lim_q    <= eff_lim;
					bw_q     <= eff_bw + vlrs_pkg::LEN_W'(do_wr);
					cnt_q    <= '0;
					status_q <= (last_q && !eff_acc) ? vlrs_pkg::ST_FULL : vlrs_pkg::ST_OK;
				end else begin
					open_q   <= 1'b0;
					acc_ok_q <= 1'b0;
					bw_q     <= '0;
					case (op_q)
						vlrs_pkg::OP_POP, vlrs_pkg::OP_PEEK: begin
							if (top_q < vlrs_pkg::PTR_W'(vlrs_pkg::LENGTH_BYTES)) begin
								top_q    <= '0;
								status_q <= vlrs_pkg::ST_EMPTY;
							end else begin
								status_q <= vlrs_pkg::ST_OK;
								t_q      <= top_q - vlrs_pkg::PTR_W'(vlrs_pkg::LENGTH_BYTES);
								cnt_q    <= vlrs_pkg::CNT_W'(vlrs_pkg::LENGTH_BYTES - 1);
								tlen_q   <= '0;
								big_q    <= 1'b0;
							end
						end
						vlrs_pkg::OP_CLEAR: begin
							top_q    <= '0;
							status_q <= vlrs_pkg::ST_OK;
						end
						vlrs_pkg::OP_PROBE: begin
							status_q <= fits ? vlrs_pkg::ST_OK : vlrs_pkg::ST_FULL;
						end
						default: begin
							status_q <= vlrs_pkg::ST_OK;
						end
					endcase
				end
			end
			if (cmd.trail_wr) begin
				cnt_q <= cnt_q + vlrs_pkg::CNT_W'(1);
				if (cnt_q == vlrs_pkg::CNT_W'(vlrs_pkg::LENGTH_BYTES - 1)) begin
					top_q    <= trail_end;
					open_q   <= 1'b0;
					acc_ok_q <= 1'b0;
					bw_q     <= '0;
				end
			end
			// trailer read high byte first, saturating above the record limit
			if (cmd.trd_cap) begin
				big_q  <= big_q || (tlen_q != '0) || (rd_q > 8'(vlrs_pkg::MAX_RECORD));
				tlen_q <= vlrs_pkg::LEN_W'(rd_q);
				cnt_q  <= cnt_q - vlrs_pkg::CNT_W'(1);
			end
			if (cmd.calc_stored) begin
				stored_q <= stored_cl;
			end
			if (cmd.calc_start) begin
				start_q <= start_c;
				n_q     <= n_c;
				idx_q   <= '0;
				if (op_q == vlrs_pkg::OP_POP) begin
					top_q <= start_c;
				end
			end
			if (cmd.load_byte) begin
				idx_q <= idx_q + vlrs_pkg::LEN_W'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_res || cmd.load_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_res || cmd.load_byte) begin
			out_status_q <= cmd.load_byte ? vlrs_pkg::ST_OK : status_q;
			out_byte_q   <= cmd.load_byte ? rd_q : 8'h00;
			has_q        <= cmd.load_byte;
			final_q      <= cmd.load_res || ((idx_q + vlrs_pkg::LEN_W'(1)) == n_q);
			empty_q      <= top_q == '0;
			used_q       <= top_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign out_byte   = out_byte_q;
	assign has_byte   = has_q;
	assign final_res  = final_q;
	assign is_empty   = empty_q;
	assign used_bytes = used_q;

	`VLRS_ASSERT_ALWAYS(a_top_in_store, clk, arst_n, top_q <= vlrs_pkg::PTR_W'(vlrs_pkg::STORE_BYTES), "top beyond store")
	`VLRS_ASSERT_IMPLY(a_open_fits, clk, arst_n, open_q && acc_ok_q, (vlrs_pkg::FIT_W'(base_q) + vlrs_pkg::FIT_W'(bw_q) + vlrs_pkg::FIT_W'(vlrs_pkg::LENGTH_BYTES)) <= vlrs_pkg::FIT_W'(vlrs_pkg::STORE_BYTES), "open record overruns store")

endmodule

// ===== rtl/vlrs_ctrl.sv =====
// controller state machine of the record stack, sequencing the datapath
// depends on vlrs_pkg and assert_macros.svh
`include "assert_macros.svh"

module vlrs_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  vlrs_pkg::sts_t sts,
	output vlrs_pkg::cmd_t cmd
);

	vlrs_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vlrs_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			vlrs_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = vlrs_pkg::S_EXEC;
				end
			end
			vlrs_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
				case (sts.op)
					vlrs_pkg::OP_PUSH: begin
						state_d = (sts.last && sts.rec_accept) ? vlrs_pkg::S_TRAIL :
							vlrs_pkg::S_RES;
					end
					vlrs_pkg::OP_POP, vlrs_pkg::OP_PEEK: begin
						state_d = sts.top_short ? vlrs_pkg::S_RES : vlrs_pkg::S_TRD;
					end
					default: begin
						state_d = vlrs_pkg::S_RES;
					end
				endcase
			end
			vlrs_pkg::S_TRAIL: begin
				cmd.trail_wr = 1'b1;
				if (sts.cnt_top) begin
					state_d = vlrs_pkg::S_RES;
				end
			end
			vlrs_pkg::S_TRD: begin
				cmd.trd_rd = 1'b1;
				state_d    = vlrs_pkg::S_TCAP;
			end
			vlrs_pkg::S_TCAP: begin
				cmd.trd_cap = 1'b1;
				state_d     = sts.cnt_zero ? vlrs_pkg::S_CALC : vlrs_pkg::S_TRD;
			end
			vlrs_pkg::S_CALC: begin
				cmd.calc_stored = 1'b1;
				state_d         = vlrs_pkg::S_START;
			end
			vlrs_pkg::S_START: begin
				cmd.calc_start = 1'b1;
				state_d        = vlrs_pkg::S_BRD;
			end
			vlrs_pkg::S_BRD: begin
				if (sts.n_zero) begin
					state_d = vlrs_pkg::S_RES;
				end else begin
					cmd.byte_rd = 1'b1;
					state_d     = vlrs_pkg::S_BOUT;
				end
			end
			vlrs_pkg::S_BOUT: begin
				if (sts.out_free) begin
					cmd.load_byte = 1'b1;
					state_d       = sts.idx_last ? vlrs_pkg::S_IDLE : vlrs_pkg::S_BRD;
				end
			end
			vlrs_pkg::S_RES: begin
				if (sts.out_free) begin
					cmd.load_res = 1'b1;
					state_d      = vlrs_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = vlrs_pkg::S_IDLE;
			end
		endcase
	end

	`VLRS_ASSERT_NEXT(a_accept_execs, clk, arst_n, state_q == vlrs_pkg::S_IDLE && in_valid, state_q == vlrs_pkg::S_EXEC, "accepted word not executed")
	`VLRS_ASSERT_IMPLY(a_load_when_free, clk, arst_n, cmd.load_res || cmd.load_byte, sts.out_free, "output register overwritten")

endmodule

// ===== rtl/variable_length_record_stack_core.sv =====
// top level of the variable-length record stack: controller plus datapath
// depends on vlrs_pkg, vlrs_ctrl and vlrs_dp
//
// channel  direction  handshake            word
// in       receive    in_valid/in_stall    operation, data_byte, record_length, last_byte
// out      send       out_valid/out_stall  status, out_byte, has_byte, final_res,
//                                          is_empty, used_bytes
//
// one word at a time: push, clear, probe pass execute and result, a closing push also
// writes the LENGTH_BYTES trailer bytes; pop and peek read the trailer unless the stack
// is empty, then read and send each record byte in turn, with a separate result only when
// none is returned; the byte store has a single read port (trailer then record bytes)
// a result sits in the output register while the next word is taken
// out_stall only holds the sequencer when a new result finds the register full
// reset empties the stack at once; the byte store needs no clearing pass

module variable_length_record_stack_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [2:0]                 operation,
	input  logic [7:0]                 data_byte,
	input  logic [vlrs_pkg::LEN_W-1:0] record_length,
	input  logic                       last_byte,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 status,
	output logic [7:0]                 out_byte,
	output logic                       has_byte,
	output logic                       final_res,
	output logic                       is_empty,
	output logic [vlrs_pkg::PTR_W-1:0] used_bytes
);

	vlrs_pkg::cmd_t cmd;
	vlrs_pkg::sts_t sts;

	vlrs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	vlrs_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.operation     (operation),
		.data_byte     (data_byte),
		.record_length (record_length),
		.last_byte     (last_byte),
		.cmd           (cmd),
		.sts           (sts),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.out_byte      (out_byte),
		.has_byte      (has_byte),
		.final_res     (final_res),
		.is_empty      (is_empty),
		.used_bytes    (used_bytes)
	);

endmodule
